// ----- sv/p2rgb_pkg.sv -----
// ----------------------------------------------------------------------------
// p2rgb_pkg
// types and constants shared by the scanline to rgb888 converter
// ----------------------------------------------------------------------------
package p2rgb_pkg;

	// pixel formats
	localparam logic [2:0] FMT_RGBA       = 3'd0;
	localparam logic [2:0] FMT_RGB        = 3'd1;
	localparam logic [2:0] FMT_INDEXED    = 3'd2;
	localparam logic [2:0] FMT_GRAY_ALPHA = 3'd3;
	localparam logic [2:0] FMT_GRAY       = 3'd4;

	// register word index, paddr[3:2]
	localparam logic [1:0] REG_FORMAT = 2'd0;
	localparam logic [1:0] REG_DEPTH  = 2'd1;
	localparam logic [1:0] REG_TRANS  = 2'd2;
	localparam logic [1:0] REG_KEY    = 2'd3;

	// output queue depth
	localparam int QDEPTH = 4;

	typedef struct packed {
		logic        func;
		logic [31:0] pixel_word;
		logic [7:0]  pal_index;
		logic [23:0] pal_rgb;
		logic [7:0]  pal_alpha;
		logic        line_end;
	} src_t;

	typedef struct packed {
		logic [7:0] red;
		logic [7:0] green;
		logic [7:0] blue;
		logic       run_last;
		logic       line_last;
	} pix_t;

	typedef struct packed {
		logic [2:0]  pixel_format;
		logic [3:0]  bit_depth;
		logic        transparency_on;
		logic [23:0] key_color;
	} cfg_t;

	// one slice or palette write handed to the pixel pipe
	typedef struct packed {
		logic       pw;
		logic       pix;
		logic       idx;
		logic       blank;
		logic [7:0] x0;
		logic [7:0] x1;
		logic [7:0] x2;
		logic [7:0] a;
		logic [7:0] addr;
		logic       run_last;
		logic       line_last;
	} op_t;

endpackage

// ----- sv/p2rgb_issue.sv -----
// ----------------------------------------------------------------------------
// p2rgb_issue
// holds the current request; issues one slice per cycle while the queue has room
// ----------------------------------------------------------------------------
module p2rgb_issue (
	input  logic              clk,
	input  logic              arst_n,
	input  p2rgb_pkg::cfg_t   cfg,
	input  logic              src_valid,
	output logic              src_stall,
	input  p2rgb_pkg::src_t   src_data,
	input  logic              room,
	output logic              op_valid,
	output p2rgb_pkg::op_t    op
);
	import p2rgb_pkg::*;

	logic       busy_q;
	src_t       item_q;
	logic [7:0] sh_q;
	logic [2:0] cnt_q;

	logic [7:0] slice;
	logic [7:0] gray;
	logic [7:0] sh_next;
	logic [2:0] nslice;
	logic [2:0] nload;
	logic       packed_fmt;
	logic       last;
	logic       needs_room;
	logic       accept;
	logic [31:0] w;

	assign w = item_q.pixel_word;

	always_comb begin
		case (cfg.bit_depth)
			4'd1: begin
				slice   = {7'b0, sh_q[7]};
				gray    = {8{sh_q[7]}};
				sh_next = {sh_q[6:0], 1'b0};
				nslice  = 3'd7;
			end
			4'd2: begin
				slice   = {6'b0, sh_q[7:6]};
				gray    = {4{sh_q[7:6]}};
				sh_next = {sh_q[5:0], 2'b0};
				nslice  = 3'd3;
			end
			4'd4: begin
				slice   = {4'b0, sh_q[7:4]};
				gray    = {2{sh_q[7:4]}};
				sh_next = {sh_q[3:0], 4'b0};
				nslice  = 3'd1;
			end
			default: begin
				slice   = sh_q;
				gray    = sh_q;
				sh_next = sh_q;
				nslice  = 3'd0;
			end
		endcase
	end

	assign packed_fmt = (cfg.pixel_format == FMT_INDEXED) || (cfg.pixel_format == FMT_GRAY);
	assign nload      = (src_data.func && packed_fmt) ? nslice : 3'd0;
	assign last       = (cnt_q == 3'd0);

	always_comb begin
		op           = '0;
		op.run_last  = last;
		op.line_last = last & item_q.line_end;
		if (!item_q.func) begin
			op.pw   = 1'b1;
			op.x0   = item_q.pal_rgb[23:16];
			op.x1   = item_q.pal_rgb[15:8];
			op.x2   = item_q.pal_rgb[7:0];
			op.a    = cfg.transparency_on ? item_q.pal_alpha : 8'hff;
			op.addr = item_q.pal_index;
		end else begin
			case (cfg.pixel_format)
				FMT_RGBA: begin
					op.pix = 1'b1;
					op.x0  = w[7:0];
					op.x1  = w[15:8];
					op.x2  = w[23:16];
					op.a   = w[31:24];
				end
				FMT_RGB: begin
					op.pix   = 1'b1;
					op.x0    = w[7:0];
					op.x1    = w[15:8];
					op.x2    = w[23:16];
					op.a     = 8'hff;
					op.blank = cfg.transparency_on
						&& ({w[7:0], w[15:8], w[23:16]} == cfg.key_color);
				end
				FMT_GRAY_ALPHA: begin
					op.pix = 1'b1;
					op.x0  = w[7:0];
					op.x1  = w[7:0];
					op.x2  = w[7:0];
					op.a   = w[15:8];
				end
				FMT_INDEXED: begin
					op.pix  = 1'b1;
					op.idx  = 1'b1;
					op.addr = slice;
				end
				FMT_GRAY: begin
					op.pix   = 1'b1;
					op.x0    = gray;
					op.x1    = gray;
					op.x2    = gray;
					op.a     = 8'hff;
					op.blank = cfg.transparency_on && (slice == cfg.key_color[7:0]);
				end
				default: ;
			endcase
		end
	end

	// unused formats issue a bubble and need no queue space
	assign needs_room = op.pix;
	assign op_valid   = busy_q && (!needs_room || room);
	assign src_stall  = busy_q && !(op_valid && last);
	assign accept     = src_valid && !src_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= 3'd0;
		end else begin
			if (accept) begin
				busy_q <= 1'b1;
				cnt_q  <= nload;
			end else if (op_valid) begin
				if (last)
					busy_q <= 1'b0;
				else
					cnt_q <= cnt_q - 3'd1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			item_q <= src_data;
			sh_q   <= src_data.pixel_word[7:0];
		end else if (op_valid) begin
			sh_q <= sh_next;
		end
	end

endmodule

// ----- sv/p2rgb_pixel.sv -----
// ----------------------------------------------------------------------------
// p2rgb_pixel
// alpha multiply pipe around the palette memory
// ----------------------------------------------------------------------------
module p2rgb_pixel #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              op_valid,
	input  p2rgb_pkg::op_t    op,
	output logic              push,
	output p2rgb_pkg::pix_t   push_data
);
	import p2rgb_pkg::*;

	localparam int AW = $clog2(PALETTE_ENTRIES);

	logic [23:0] pal_mem [PALETTE_ENTRIES];

	logic          pix_s1;
	logic          pw_s1;
	logic          idx_s1;
	logic          blank_s1;
	logic          oor_s1;
	logic          run_last_s1;
	logic          line_last_s1;
	logic          fwd_s1;
	logic [15:0]   prod0_s1;
	logic [15:0]   prod1_s1;
	logic [15:0]   prod2_s1;
	logic [AW-1:0] addr_s1;
	logic [23:0]   rdata_s1;
	logic [23:0]   fwd_data_s1;

	logic          oor;
	logic          we;
	logic          fwd;
	logic [23:0]   wdata;
	logic [23:0]   col;

	// round(p/255) for p = x*a, exact over the 16 bit product range
	function automatic logic [7:0] div255(input logic [15:0] p);
		logic [16:0] t;
		logic [16:0] u;
		t = {1'b0, p} + 17'd127;
		u = t + {8'b0, t[16:8]} + 17'd1;
		return u[15:8];
	endfunction

	assign oor   = ({1'b0, op.addr} >= 9'(PALETTE_ENTRIES));
	assign wdata = {div255(prod0_s1), div255(prod1_s1), div255(prod2_s1)};
	assign we    = pw_s1 && !oor_s1;
	// write lands at the same edge as the next read: pass it over
	assign fwd   = op_valid && op.idx && we && (op.addr[AW-1:0] == addr_s1);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pix_s1 <= 1'b0;
			pw_s1  <= 1'b0;
		end else begin
			pix_s1 <= op_valid && op.pix;
			pw_s1  <= op_valid && op.pw;
		end
	end

	always_ff @(posedge clk) begin
		prod0_s1     <= {8'd0, op.x0} * {8'd0, op.a};
		prod1_s1     <= {8'd0, op.x1} * {8'd0, op.a};
		prod2_s1     <= {8'd0, op.x2} * {8'd0, op.a};
		idx_s1       <= op.idx;
		blank_s1     <= op.blank;
		oor_s1       <= oor;
		addr_s1      <= op.addr[AW-1:0];
		run_last_s1  <= op.run_last;
		line_last_s1 <= op.line_last;
		fwd_s1       <= fwd;
		fwd_data_s1  <= wdata;
	end

	always_ff @(posedge clk) begin
		if (we)
			pal_mem[addr_s1] <= wdata;
		if (op_valid && op.idx)
			rdata_s1 <= pal_mem[op.addr[AW-1:0]];
	end

	always_comb begin
		if (blank_s1)
			col = 24'd0;
		else if (idx_s1)
			col = oor_s1 ? 24'd0 : (fwd_s1 ? fwd_data_s1 : rdata_s1);
		else
			col = wdata;
	end

	assign push                = pix_s1;
	assign push_data.red       = col[23:16];
	assign push_data.green     = col[15:8];
	assign push_data.blue      = col[7:0];
	assign push_data.run_last  = run_last_s1;
	assign push_data.line_last = line_last_s1;

endmodule

// ----- sv/p2rgb_outq.sv -----
// ----------------------------------------------------------------------------
// p2rgb_outq
// small output queue that absorbs the pipe while the receiver stalls
// ----------------------------------------------------------------------------
module p2rgb_outq (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  p2rgb_pkg::pix_t   push_data,
	output logic              pix_valid,
	input  logic              pix_stall,
	output p2rgb_pkg::pix_t   pix_data,
	output logic [2:0]        count
);
	import p2rgb_pkg::*;

	pix_t       ent_q [QDEPTH];
	logic [1:0] wr_q;
	logic [1:0] rd_q;
	logic [2:0] cnt_q;
	logic       pop;

	assign pix_valid = (cnt_q != 3'd0);
	assign pix_data  = ent_q[rd_q];
	assign pop       = pix_valid && !pix_stall;
	assign count     = cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 2'd0;
			rd_q  <= 2'd0;
			cnt_q <= 3'd0;
		end else begin
			if (push)
				wr_q <= wr_q + 2'd1;
			if (pop)
				rd_q <= rd_q + 2'd1;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 3'd1;
				2'b01:   cnt_q <= cnt_q - 3'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			ent_q[wr_q] <= push_data;
	end

endmodule

// ----- sv/png_scanline_to_rgb888.sv -----
// ----------------------------------------------------------------------------
// png_scanline_to_rgb888
// decoded png scanline requests in, rgb888 pixels out, one pixel per cycle unless stalled
//
// src channel: one request per item, either a palette entry write (func 0)
// or one pixel data word (func 1). pix channel: rgb888 pixels, run_last on
// the last pixel of each request, line_last on that pixel when line_end was
// set. both sides handshake with valid and stall. the four registers sit on
// the apb port and must be written by the user only while the block is idle;
// the block does not enforce it. a request's pixels pass the s1 registers and
// the output queue. one pixel per cycle while the queue has room, set by the
// single issue slot in front of the alpha multipliers and the palette read
// port; a rgba, rgb or gray+alpha request yields one pixel, a packed byte
// 8/bit_depth at depth 1, 2 or 4 and one otherwise, a palette write none.
// while pix_stall is high the four-entry output queue fills and then src is
// stalled; nothing is lost. reset empties the pipe and queue and restores
// the register defaults; palette contents are undefined until written.
// ----------------------------------------------------------------------------
module png_scanline_to_rgb888 #(
	parameter int PALETTE_ENTRIES = 256
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              src_valid,
	output logic              src_stall,
	input  p2rgb_pkg::src_t   src_data,
	output logic              pix_valid,
	input  logic              pix_stall,
	output p2rgb_pkg::pix_t   pix_data,
	input  logic              psel,
	input  logic              penable,
	input  logic              pwrite,
	input  logic [3:0]        paddr,
	input  logic [31:0]       pwdata,
	output logic [31:0]       prdata,
	output logic              pready
);
	import p2rgb_pkg::*;

	cfg_t       cfg_q;
	logic       cfg_wr;
	logic       room;
	logic       op_valid;
	op_t        op;
	logic       push;
	pix_t       push_data;
	logic [2:0] q_count;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.pixel_format    <= FMT_RGB;
			cfg_q.bit_depth       <= 4'd8;
			cfg_q.transparency_on <= 1'b0;
			cfg_q.key_color       <= 24'd0;
		end else if (cfg_wr) begin
			case (paddr[3:2])
				REG_FORMAT: cfg_q.pixel_format    <= pwdata[2:0];
				REG_DEPTH:  cfg_q.bit_depth       <= pwdata[3:0];
				REG_TRANS:  cfg_q.transparency_on <= pwdata[0];
				REG_KEY:    cfg_q.key_color       <= pwdata[23:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_FORMAT: prdata = {29'd0, cfg_q.pixel_format};
			REG_DEPTH:  prdata = {28'd0, cfg_q.bit_depth};
			REG_TRANS:  prdata = {31'd0, cfg_q.transparency_on};
			REG_KEY:    prdata = {8'd0, cfg_q.key_color};
			default:    prdata = 32'd0;
		endcase
	end

	// queued pixels plus the one in flight must leave a free entry
	assign room = ({1'b0, q_count} + {3'd0, push}) < 4'(QDEPTH);

	p2rgb_issue u_issue (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg_q),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.room      (room),
		.op_valid  (op_valid),
		.op        (op)
	);

	p2rgb_pixel #(
		.PALETTE_ENTRIES (PALETTE_ENTRIES)
	) u_pixel (
		.clk       (clk),
		.arst_n    (arst_n),
		.op_valid  (op_valid),
		.op        (op),
		.push      (push),
		.push_data (push_data)
	);

	p2rgb_outq u_outq (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.count     (q_count)
	);

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (q_count < 3'(QDEPTH)))
		else $error("output queue overflow");

	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		(op_valid && !op.pix) |=> !push)
		else $error("pixel pushed for a request that has none");

	a_line_on_run: assert property (@(posedge clk) disable iff (!arst_n)
		(pix_valid && pix_data.line_last) |-> pix_data.run_last)
		else $error("line_last without run_last");

endmodule

// ----- verif/png_scanline_to_rgb888_tb.sv -----
// ----------------------------------------------------------------------------
// png_scanline_to_rgb888 testbench
// drives palette writes and pixel data words through every pixel format and
// bit depth, predicts the rgb888 pixels and checks each one as it leaves
// ----------------------------------------------------------------------------
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import p2rgb_pkg::*;

	localparam int PAL_ENTRIES  = 256;
	localparam int DRAIN_CYCLES = 8;
	localparam int SETTLE_LIMIT = 20000;
	localparam int MAX_REPORTS  = 10;
	localparam int RANDOM_ITEMS = 190;
	localparam logic [2:0] FMT_SPARE_LO = 3'd5;
	localparam logic [2:0] FMT_SPARE_HI = 3'd7;
	localparam logic       FUNC_PALETTE = 1'b0;
	localparam logic       FUNC_PIXEL   = 1'b1;

	logic        clk       = 1'b0;
	logic        arst_n    = 1'b0;
	logic        src_valid = 1'b0;
	src_t        src_data  = '0;
	logic        pix_stall = 1'b0;
	logic        psel      = 1'b0;
	logic        penable   = 1'b0;
	logic        pwrite    = 1'b0;
	logic [3:0]  paddr     = '0;
	logic [31:0] pwdata    = '0;
	logic        src_stall;
	logic        pix_valid;
	pix_t        pix_data;
	logic [31:0] prdata;
	logic        pready;

	// register shadow, starts at the reset defaults
	cfg_t        regs = '{pixel_format: FMT_RGB, bit_depth: 4'd8, transparency_on: 1'b0,
		key_color: 24'h0};
	logic [23:0] palette_shadow [PAL_ENTRIES];
	bit          entry_loaded [PAL_ENTRIES];
	int          loaded_entries [$];
	pix_t        pixels_due [$];
	pix_t        want;
	int          failures   = 0;
	int          stall_left = 0;
	int          sent       = 0;
	bit          idle_off   = 1'b0;

	png_scanline_to_rgb888 dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.src_valid (src_valid),
		.src_stall (src_stall),
		.src_data  (src_data),
		.pix_valid (pix_valid),
		.pix_stall (pix_stall),
		.pix_data  (pix_data),
		.psel      (psel),
		.penable   (penable),
		.pwrite    (pwrite),
		.paddr     (paddr),
		.pwdata    (pwdata),
		.prdata    (prdata),
		.pready    (pready)
	);

	always #5 clk = ~clk;

	function automatic logic [7:0] alpha_scale(logic [7:0] x, logic [7:0] a);
		int unsigned p;
		p = int'(x) * int'(a) + 127;
		return 8'(p / 255);
	endfunction

	function automatic int slice_width(logic [3:0] depth);
		if (depth == 4'd1 || depth == 4'd2 || depth == 4'd4) begin
			return int'(depth);
		end
		return 8;
	endfunction

	function automatic pix_t grey_pixel(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		pix_t p;
		p.red       = r;
		p.green     = g;
		p.blue      = b;
		p.run_last  = 1'b0;
		p.line_last = 1'b0;
		return p;
	endfunction

	// works out the pixels one request yields, or applies a palette write
	task automatic convert_request(src_t r);
		pix_t        run [$];
		int          d;
		int          sh;
		logic [7:0]  mask;
		logic [7:0]  gain;
		logic [7:0]  s;
		logic [7:0]  v;
		logic [7:0]  packed_in;
		logic [23:0] c;
		logic [23:0] px;
		logic [31:0] w;
		w = r.pixel_word;
		if (r.func == FUNC_PALETTE) begin
			c = r.pal_rgb;
			if (regs.transparency_on) begin
				c = {alpha_scale(c[23:16], r.pal_alpha), alpha_scale(c[15:8], r.pal_alpha),
					alpha_scale(c[7:0], r.pal_alpha)};
			end
			palette_shadow[r.pal_index] = c;
			if (!entry_loaded[r.pal_index]) begin
				entry_loaded[r.pal_index] = 1'b1;
				loaded_entries.push_back(int'(r.pal_index));
			end
			return;
		end
		case (regs.pixel_format)
			FMT_RGBA: begin
				run.push_back(grey_pixel(alpha_scale(w[7:0], w[31:24]),
					alpha_scale(w[15:8], w[31:24]), alpha_scale(w[23:16], w[31:24])));
			end
			FMT_RGB: begin
				px = {w[7:0], w[15:8], w[23:16]};
				if (regs.transparency_on && px == regs.key_color)
					run.push_back(grey_pixel(8'h00, 8'h00, 8'h00));
				else
					run.push_back(grey_pixel(w[7:0], w[15:8], w[23:16]));
			end
			FMT_GRAY_ALPHA: begin
				v = alpha_scale(w[7:0], w[15:8]);
				run.push_back(grey_pixel(v, v, v));
			end
			FMT_INDEXED, FMT_GRAY: begin
				d         = slice_width(regs.bit_depth);
				mask      = 8'((1 << d) - 1);
				gain      = (d == 1) ? 8'd255 : (d == 2) ? 8'd85 : (d == 4) ? 8'd17 : 8'd1;
				packed_in = w[7:0];
				for (sh = 8 - d; sh >= 0; sh -= d) begin
					s = (packed_in >> sh) & mask;
					if (regs.pixel_format == FMT_INDEXED) begin
						c = palette_shadow[s];
						run.push_back(grey_pixel(c[23:16], c[15:8], c[7:0]));
					end else begin
						if (regs.transparency_on && s == regs.key_color[7:0])
							v = 8'h00;
						else
							v = 8'(s * gain);
						run.push_back(grey_pixel(v, v, v));
					end
				end
			end
			default: ;
		endcase
		if (run.size() != 0) begin
			run[run.size() - 1].run_last  = 1'b1;
			run[run.size() - 1].line_last = r.line_end;
			foreach (run[i]) pixels_due.push_back(run[i]);
		end
	endtask

	function automatic src_t pixel_request(logic [31:0] w, logic lend);
		src_t r;
		r.func       = FUNC_PIXEL;
		r.pixel_word = w;
		r.pal_index  = 8'($urandom);
		r.pal_rgb    = 24'($urandom);
		r.pal_alpha  = 8'($urandom);
		r.line_end   = lend;
		return r;
	endfunction

	function automatic src_t palette_request(logic [7:0] idx, logic [23:0] rgb, logic [7:0] a);
		src_t r;
		r.func       = FUNC_PALETTE;
		r.pixel_word = $urandom;
		r.pal_index  = idx;
		r.pal_rgb    = rgb;
		r.pal_alpha  = a;
		r.line_end   = 1'($urandom);
		return r;
	endfunction

	// one request, with a random gap before it unless idling is off
	task automatic send_request(src_t r);
		if (!idle_off && $urandom_range(0, 3) == 0) begin
			src_valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(posedge clk);
		end
		src_valid <= 1'b1;
		src_data  <= r;
		do @(posedge clk); while (src_stall);
		convert_request(r);
		sent++;
	endtask

	// wait for every expected pixel, then let the pipe empty
	task automatic settle();
		int n;
		n = 0;
		src_valid <= 1'b0;
		do begin
			@(posedge clk);
			n++;
		end while (pixels_due.size() != 0 && n < SETTLE_LIMIT);
		if (pixels_due.size() != 0) begin
			if (failures < MAX_REPORTS)
				$display("%0d expected pixels never arrived", pixels_due.size());
			failures++;
			pixels_due.delete();
		end
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(logic [1:0] idx, logic [31:0] val);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= {idx, 2'b00};
		pwdata  <= val;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		case (idx)
			REG_FORMAT: regs.pixel_format    = val[2:0];
			REG_DEPTH:  regs.bit_depth       = val[3:0];
			REG_TRANS:  regs.transparency_on = val[0];
			REG_KEY:    regs.key_color       = val[23:0];
			default: ;
		endcase
		@(posedge clk);
	endtask

	task automatic configure(logic [2:0] fmt, logic [3:0] depth, logic trans, logic [23:0] key);
		settle();
		write_reg(REG_FORMAT, 32'(fmt));
		write_reg(REG_DEPTH, 32'(depth));
		write_reg(REG_TRANS, 32'(trans));
		write_reg(REG_KEY, 32'(key));
	endtask

	// results side
	always @(posedge clk) begin
		if (arst_n && pix_valid && !pix_stall) begin
			if (pixels_due.size() == 0) begin
				if (failures < MAX_REPORTS)
					$display("unexpected pixel r %02h g %02h b %02h run %b line %b",
						pix_data.red, pix_data.green, pix_data.blue,
						pix_data.run_last, pix_data.line_last);
				failures++;
			end else begin
				want = pixels_due.pop_front();
				if (pix_data.red !== want.red || pix_data.green !== want.green ||
					pix_data.blue !== want.blue || pix_data.run_last !== want.run_last ||
					pix_data.line_last !== want.line_last) begin
					if (failures < MAX_REPORTS)
						$display({"pixel mismatch: expected r %02h g %02h b %02h run %b line %b,",
							" got r %02h g %02h b %02h run %b line %b"},
							want.red, want.green, want.blue, want.run_last, want.line_last,
							pix_data.red, pix_data.green, pix_data.blue,
							pix_data.run_last, pix_data.line_last);
					failures++;
				end
			end
		end
	end

	// receiver stalls in bursts
	always @(posedge clk) begin
		if (stall_left > 1) begin
			stall_left <= stall_left - 1;
		end else if (!idle_off && $urandom_range(0, 4) == 0) begin
			pix_stall  <= 1'b1;
			stall_left <= $urandom_range(1, 8);
		end else begin
			pix_stall  <= 1'b0;
			stall_left <= 0;
		end
	end

	task automatic test_reset_defaults();
		send_request(pixel_request(32'h0000_0000, 1'b0));
		send_request(pixel_request(32'hffff_ffff, 1'b1));
		send_request(pixel_request($urandom, 1'b0));
	endtask

	task automatic test_rgba();
		configure(FMT_RGBA, 4'd8, 1'b0, 24'h0);
		send_request(pixel_request(32'hffff_ffff, 1'b1));
		send_request(pixel_request(32'h00ff_ffff, 1'b0));
		send_request(pixel_request({8'h80, 24'($urandom)}, 1'b1));
	endtask

	task automatic test_rgb_key();
		configure(FMT_RGB, 4'd8, 1'b1, 24'h123456);
		send_request(pixel_request(32'ha556_3412, 1'b0));
		send_request(pixel_request(32'h0056_3413, 1'b1));
		configure(FMT_RGB, 4'd8, 1'b1, 24'hffffff);
		send_request(pixel_request(32'h00ff_ffff, 1'b0));
	endtask

	task automatic test_gray_alpha();
		configure(FMT_GRAY_ALPHA, 4'd8, 1'b0, 24'h0);
		send_request(pixel_request(32'h0000_ffff, 1'b1));
		send_request(pixel_request(32'hffff_00ff, 1'b0));
	endtask

	task automatic test_gray_depths();
		configure(FMT_GRAY, 4'd1, 1'b0, 24'h0);
		send_request(pixel_request({24'($urandom), 8'ha5}, 1'b1));
		configure(FMT_GRAY, 4'd2, 1'b1, 24'hfedc02);
		send_request(pixel_request({24'($urandom), 8'h1b}, 1'b0));
		configure(FMT_GRAY, 4'd4, 1'b0, 24'h0);
		send_request(pixel_request({24'($urandom), 8'hf0}, 1'b1));
		configure(FMT_GRAY, 4'd8, 1'b0, 24'h0);
		send_request(pixel_request({24'($urandom), 8'hff}, 1'b0));
		// depth that is not 1, 2 or 4 behaves as 8
		configure(FMT_GRAY, 4'd15, 1'b1, 24'h0);
		send_request(pixel_request({24'($urandom), 8'h00}, 1'b1));
	endtask

	task automatic test_palette_indexed();
		configure(FMT_INDEXED, 4'd1, 1'b0, 24'h0);
		send_request(palette_request(8'd0, 24'($urandom), 8'($urandom)));
		send_request(palette_request(8'd1, 24'hffffff, 8'h00));
		configure(FMT_INDEXED, 4'd1, 1'b1, 24'h0);
		send_request(palette_request(8'd2, 24'hffffff, 8'hff));
		send_request(palette_request(8'd3, 24'($urandom), 8'h80));
		send_request(palette_request(8'd255, 24'($urandom), 8'($urandom)));
		send_request(pixel_request({24'($urandom), 8'ha5}, 1'b1));
		configure(FMT_INDEXED, 4'd2, 1'b0, 24'h0);
		send_request(pixel_request({24'($urandom), 8'he4}, 1'b0));
		configure(FMT_INDEXED, 4'd8, 1'b0, 24'h0);
		send_request(pixel_request({24'($urandom), 8'hff}, 1'b1));
	endtask

	task automatic test_spare_formats();
		configure(FMT_SPARE_HI, 4'd8, 1'b0, 24'h0);
		send_request(pixel_request($urandom, 1'b1));
		send_request(palette_request(8'd4, 24'($urandom), 8'($urandom)));
		configure(FMT_SPARE_LO, 4'd0, 1'b0, 24'h0);
		send_request(pixel_request($urandom, 1'b0));
	endtask

	// one setting, then a run of mostly well-formed pixel requests
	task automatic random_phase(int count);
		logic [2:0]  fmt;
		logic [3:0]  depth;
		logic        trans;
		logic [23:0] key;
		logic [7:0]  sample;
		logic [31:0] w;
		int          pick;
		pick = $urandom_range(0, 19);
		fmt  = (pick < 19) ? 3'(pick % 5) : 3'($urandom_range(5, 7));
		case ($urandom_range(0, 4))
			0: depth = 4'd1;
			1: depth = 4'd2;
			2: depth = 4'd4;
			3: depth = 4'd8;
			default: depth = 4'($urandom);
		endcase
		trans = 1'($urandom);
		key   = 24'($urandom);
		if (fmt == FMT_GRAY && $urandom_range(0, 3) != 0)
			key[7:0] = 8'($urandom_range(0, (1 << slice_width(depth)) - 1));
		configure(fmt, depth, trans, key);
		repeat (count) begin
			if ($urandom_range(0, 9) == 0) begin
				send_request(palette_request(8'($urandom), 24'($urandom), 8'($urandom)));
			end else begin
				w = $urandom;
				if (fmt == FMT_RGB && trans && $urandom_range(0, 2) == 0)
					w[23:0] = {key[7:0], key[15:8], key[23:16]};
				if (fmt == FMT_INDEXED && slice_width(depth) == 8) begin
					// only entries that hold a written colour are looked up
					sample  = 8'(loaded_entries[$urandom_range(0, loaded_entries.size() - 1)]);
					w[7:0]  = sample;
				end
				send_request(pixel_request(w, $urandom_range(0, 3) == 0));
			end
		end
	endtask

	task automatic test_random();
		configure(FMT_INDEXED, 4'd4, 1'($urandom), 24'($urandom));
		for (int i = 0; i < 16; i++)
			send_request(palette_request(8'(i), 24'($urandom), 8'($urandom)));
		while (sent < RANDOM_ITEMS) begin
			idle_off = ($urandom_range(0, 3) == 0);
			random_phase($urandom_range(10, 30));
		end
	endtask

	task automatic test_back_to_back();
		idle_off = 1'b1;
		random_phase(20);
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_defaults();
		test_rgba();
		test_rgb_key();
		test_gray_alpha();
		test_gray_depths();
		test_palette_indexed();
		test_spare_formats();
		test_random();
		test_back_to_back();
		settle();
		if (failures == 0)
			$display("png_scanline_to_rgb888 verification clean");
		else
			$display("png_scanline_to_rgb888 verification failed");
		$finish;
	end

	initial begin
		#2_000_000;
		$display("png_scanline_to_rgb888 verification failed");
		$finish;
	end

endmodule

// ----- sim.f -----
sv/p2rgb_pkg.sv
sv/p2rgb_issue.sv
sv/p2rgb_pixel.sv
sv/p2rgb_outq.sv
sv/png_scanline_to_rgb888.sv
verif/png_scanline_to_rgb888_tb.sv
